@@ hw/rtl/cmw_pkg.sv @@
// Shared constants, types and helper functions for the column melt warp block.
package cmw_pkg;

    // Frame geometry and storage.
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);

    // Field widths.
    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 2 * CHAR_W;
    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int MELT_W     = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_FIELDS_W = COL_W + ROW_W + 2 * CHAR_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = CELL_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MELT = 2'd2;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd25;
    localparam logic [MELT_W-1:0]     MELT_RESET = 16'd0;

    // Item kinds carried in tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Vacated cell contents.
    localparam logic [CHAR_W-1:0] BLANK_GLYPH = 8'h20;
    localparam logic [CHAR_W-1:0] DESK_ATTR   = 8'h08;
    localparam logic [CELL_W-1:0] BLANK_CELL  = {DESK_ATTR, BLANK_GLYPH};

    // Low 24 bits of the golden-ratio hash multiplier; only hash bits 23..16 are used.
    localparam logic [23:0] HASH_MULT_LO = 24'h3779B1;

    // Q16 constants for speed and fall.
    localparam logic [15:0] Q_BASE_SPEED = 16'd29491;
    localparam logic [15:0] Q_SPAN_SPEED = 16'd36044;
    localparam logic [15:0] Q_BASE_FALL  = 16'd13107;
    localparam logic [15:0] Q_SPAN_FALL  = 16'd52428;

    // Offset unit sizing: a Q16 depth of at most 1.0 needs 17 quotient bits.
    localparam int Q_ONE_W   = 17;
    localparam int DIV_STEPS = Q_ONE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int OFF_W     = 10;

    // Request to and response from the offset unit.
    typedef struct packed {
        logic             start;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cmw_off_req_t;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] off;
    } cmw_off_rsp_t;

    // True when a coordinate lies inside the frame in use.
    function automatic logic in_frame(input logic [COL_W-1:0]      col,
                                      input logic [ROW_W-1:0]      row,
                                      input logic [COLS_CFG_W-1:0] cols,
                                      input logic [ROWS_CFG_W-1:0] rows);
        return (32'(col) < 32'(cols)) && (32'(row) < 32'(rows)) &&
               (32'(col) < MAX_COLS) && (32'(row) < MAX_ROWS);
    endfunction

    // Storage address with a fixed stride of MAX_COLS.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

@@ hw/rtl/cmw_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module cmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; read data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/cmw_offset.sv @@
// Melt offset unit: column hash speed, bit-serial depth divider and the Q16 products.
module cmw_offset import cmw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmw_off_req_t          req,
    input  logic [ROWS_CFG_W-1:0] rows_in_use,
    input  logic [MELT_W-1:0]     melt_amount,
    output cmw_off_rsp_t          rsp
);

    typedef enum logic [2:0] {
        O_IDLE,
        O_DIV,
        O_SQ,
        O_FALL,
        O_PROD
    } ostate_t;

    ostate_t              state_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [7:0]           hb_reg;
    logic [15:0]          spd_reg;
    logic [31:0]          ms_reg;
    logic [ROWS_CFG_W-1:0] divisor_reg;
    logic [ROWS_CFG_W-1:0] rem_reg;
    logic [Q_ONE_W-1:0]   num_reg;
    logic [Q_ONE_W-1:0]   quo_reg;
    logic [Q_ONE_W-1:0]   dsq_reg;
    logic [15:0]          fall_reg;
    logic [OFF_W-1:0]     off_reg;

    logic [23:0]           hprod;
    logic [ROWS_CFG_W-1:0] hm1;
    logic [16:0]           hashq;
    logic [32:0]           spd_prod;
    logic [15:0]           spd_next;
    logic [ROWS_CFG_W:0]   trial;
    logic                  ge;
    logic [ROWS_CFG_W-1:0] rem_next;
    logic [33:0]           sq_prod;
    logic [Q_ONE_W-1:0]    dsq_next;
    logic [32:0]           fall_prod;
    logic [15:0]           fall_next;
    logic [47:0]           off_prod;
    logic [OFF_W-1:0]      off_next;

    // Column hash: bits 23..16 of the column times the golden-ratio multiplier.
    assign hprod = 24'(req.col) * HASH_MULT_LO;

    // Divisor is the frame height minus one, never below one.
    assign hm1 = (rows_in_use > 7'd1) ? (rows_in_use - 7'd1) : 7'd1;

    // hb * 65536 / 255 equals hb * 257 plus one when hb is 255.
    assign hashq    = 17'({hb_reg, hb_reg}) + 17'(hb_reg == 8'hFF);
    assign spd_prod = 33'(Q_SPAN_SPEED) * 33'(hashq);
    assign spd_next = Q_BASE_SPEED + spd_prod[31:16];

    // One restoring division step per cycle.
    assign trial    = {rem_reg, num_reg[Q_ONE_W-1]};
    assign ge       = trial >= {1'b0, divisor_reg};
    assign rem_next = ge ? ROWS_CFG_W'(trial - {1'b0, divisor_reg}) : trial[ROWS_CFG_W-1:0];

    // Depth squared, fall, and the final product.
    assign sq_prod   = 34'(quo_reg) * 34'(quo_reg);
    assign dsq_next  = sq_prod[32:16];
    assign fall_prod = 33'(Q_SPAN_FALL) * 33'(dsq_reg);
    assign fall_next = Q_BASE_FALL + fall_prod[31:16];
    assign off_prod  = 48'(ms_reg) * 48'(fall_reg);
    assign off_next  = off_prod[47:38];

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= O_IDLE;
            done_reg  <= 1'b0;
        end else begin
            // The offset is ready for one cycle after the final product.
            done_reg <= (state_reg == O_PROD);
            case (state_reg)
                O_IDLE: begin
                    if (req.start) begin
                        // The row is at most the divisor inside the frame, so the
                        // quotient bits above Q16 are zero and row / 2 is the remainder.
                        hb_reg      <= hprod[23:16];
                        divisor_reg <= hm1;
                        rem_reg     <= ROWS_CFG_W'(req.row >> 1);
                        num_reg     <= {req.row[0], {(Q_ONE_W-1){1'b0}}};
                        quo_reg     <= '0;
                        step_reg    <= '0;
                        state_reg   <= O_DIV;
                    end
                end
                O_DIV: begin
                    // Speed and melt times speed settle while the divider runs.
                    spd_reg  <= spd_next;
                    ms_reg   <= 32'(melt_amount) * 32'(spd_reg);
                    rem_reg  <= rem_next;
                    num_reg  <= {num_reg[Q_ONE_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[Q_ONE_W-2:0], ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= O_SQ;
                    end
                end
                O_SQ: begin
                    dsq_reg   <= dsq_next;
                    state_reg <= O_FALL;
                end
                O_FALL: begin
                    fall_reg  <= fall_next;
                    state_reg <= O_PROD;
                end
                O_PROD: begin
                    off_reg   <= off_next;
                    state_reg <= O_IDLE;
                end
                default: begin
                    state_reg <= O_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.off  = off_reg;

endmodule

@@ hw/rtl/cell_column_melt_warp.sv @@
// Top level of the column melt warp: frame store, item sequencer and output register.
//
// The block holds a text-cell frame in an on-chip RAM and serves write and warped-read
// transfers one at a time. After reset it runs a clearing pass over MAX_COLS * MAX_ROWS
// cells (8192 at the default sizes) that fills the frame with blank desktop cells; no
// input transfer is taken during that pass, configuration writes are. A write item is
// stored in the cycle of its acceptance and leaves the input open. A read item goes
// through the offset unit, a RAM read and the load state; when the output register is
// free, its result is presented and the input reopens in that same cycle. The bit-serial
// divider of the offset unit forms row / (rows_in_use - 1) one quotient bit per cycle,
// followed by the square, fall and offset multiplies and one RAM read. A finished result
// waits in the output register while the next item is accepted; a further read result
// waits in the sequencer, with the input closed, until the output register frees.
module cell_column_melt_warp import cmw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // col[6:0], row[12:7], glyph[20:13], attribute[28:21]
    input  logic                  s_tuser,  // func: 0 write cell, 1 read warped cell
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // out_glyph[7:0], out_attribute[15:8]
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_CALC,
        T_LOAD
    } tstate_t;

    tstate_t               state_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [MELT_W-1:0]     melt_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  frame_reg;
    logic                  hit_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic [CHAR_W-1:0] in_glyph;
    logic [CHAR_W-1:0] in_attr;
    logic              s_accept;
    logic              in_hit;
    logic              src_ok;
    logic [ROW_W-1:0]  src_row;
    logic              out_free;
    logic [CELL_W-1:0] load_data;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    cmw_off_req_t off_req;
    cmw_off_rsp_t off_rsp;

    // Unpack the input payload.
    assign in_col   = s_tdata[COL_W-1:0];
    assign in_row   = s_tdata[COL_W +: ROW_W];
    assign in_glyph = s_tdata[COL_W+ROW_W +: CHAR_W];
    assign in_attr  = s_tdata[COL_W+ROW_W+CHAR_W +: CHAR_W];

    // Handshake and frame test.
    assign s_tready = (state_reg == T_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_hit   = in_frame(in_col, in_row, cols_reg, rows_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Start the offset unit on every accepted read.
    assign off_req.start = s_accept && (s_tuser == FUNC_READ);
    assign off_req.col   = in_col;
    assign off_req.row   = in_row;

    cmw_offset u_offset (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (off_req),
        .rows_in_use (rows_reg),
        .melt_amount (melt_reg),
        .rsp         (off_rsp)
    );

    // Source row lies in the frame only when the offset does not pass the top.
    assign src_ok  = frame_reg && (off_rsp.off <= OFF_W'(row_reg));
    assign src_row = row_reg - off_rsp.off[ROW_W-1:0];

    // RAM write: clearing pass first, then in-frame write items.
    always_comb begin
        if (state_reg == T_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = BLANK_CELL;
        end else begin
            ram_we    = s_accept && (s_tuser == FUNC_WRITE) && in_hit;
            ram_waddr = cell_addr(in_col, in_row);
            ram_wdata = {in_attr, in_glyph};
        end
    end

    // RAM read is issued when the offset is known.
    assign ram_re    = (state_reg == T_CALC) && off_rsp.done;
    assign ram_raddr = cell_addr(col_reg, src_row);

    cmw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign load_data = hit_reg ? ram_rdata : BLANK_CELL;

    // Sequencer, configuration registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_CLEAR;
            clr_addr_reg <= '0;
            cols_reg     <= COLS_RESET;
            rows_reg     <= ROWS_RESET;
            melt_reg     <= MELT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Configuration writes; unknown indexes are ignored.
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_COLS: cols_reg <= cfg_wr_data[COLS_CFG_W-1:0];
                    CFG_ROWS: rows_reg <= cfg_wr_data[ROWS_CFG_W-1:0];
                    CFG_MELT: melt_reg <= cfg_wr_data[MELT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // A loaded read result fills the output register; a result transfer empties it.
            if ((state_reg == T_LOAD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                T_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(CELLS - 1)) begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (off_req.start) begin
                        col_reg   <= in_col;
                        row_reg   <= in_row;
                        frame_reg <= in_hit;
                        state_reg <= T_CALC;
                    end
                end
                T_CALC: begin
                    if (off_rsp.done) begin
                        hit_reg   <= src_ok;
                        state_reg <= T_LOAD;
                    end
                end
                T_LOAD: begin
                    if (out_free) begin
                        m_tdata_reg  <= load_data;
                        state_reg    <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // The offset unit answers only while a read waits for it.
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        off_rsp.done |-> (state_reg == T_CALC))
        else $error("offset result arrived outside a pending read");

    // A read that starts the offset unit closes the input until it completes.
    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        off_req.start |=> !s_tready)
        else $error("input reopened while a read was in progress");

    // A read result placed in a free output register is presented next cycle.
    a_load_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == T_LOAD) && out_free) |=> m_tvalid)
        else $error("read result was not presented");
`endif

endmodule

@@ verif/tb_cell_column_melt_warp.sv @@
// Self-checking testbench for the column melt warp block: stream stimulus with a scoreboard.
`timescale 1ns / 100ps

module tb_cell_column_melt_warp;
    import cmw_pkg::*;

    // The only index the register map leaves unmapped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 800000;

    // Mirror of the frame store and registers, and the queue of cells that reads must return.
    class melt_scoreboard;
        bit [CELL_W-1:0]     frame [CELLS];
        bit [COLS_CFG_W-1:0] cols;
        bit [ROWS_CFG_W-1:0] rows;
        bit [MELT_W-1:0]     melt;
        bit [CELL_W-1:0]     expected_cells [$];
        int unsigned         errors;

        function new();
            foreach (frame[i]) frame[i] = BLANK_CELL;
            cols   = COLS_RESET;
            rows   = ROWS_RESET;
            melt   = MELT_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COLS: cols = data[COLS_CFG_W-1:0];
                CFG_ROWS: rows = data[ROWS_CFG_W-1:0];
                CFG_MELT: melt = data[MELT_W-1:0];
                default: ;
            endcase
        endfunction

        // Downward shift in rows for one cell: melt * speed(col) * fall(row), speed and fall Q16, melt Q10.6.
        function bit [63:0] melt_offset(bit [COL_W-1:0] col, bit [ROW_W-1:0] row);
            bit [31:0] h;
            bit [63:0] hashq, speed, hm1, depth, dsq, fall;
            h     = 32'(col) * 32'd2654435761;
            hashq = (64'(h[23:16]) << 16) / 64'd255;
            speed = 64'(Q_BASE_SPEED) + ((64'(Q_SPAN_SPEED) * hashq) >> 16);
            hm1   = (rows > 1) ? 64'(rows - 1) : 64'd1;
            depth = (64'(row) << 16) / hm1;
            dsq   = (depth * depth) >> 16;
            fall  = 64'(Q_BASE_FALL) + ((64'(Q_SPAN_FALL) * dsq) >> 16);
            return (64'(melt) * speed * fall) >> 38;
        endfunction

        function void note_item(logic func, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                logic [CHAR_W-1:0] glyph, logic [CHAR_W-1:0] attr);
            bit          in_view;
            bit [63:0]   off;
            bit [CELL_W-1:0] exp_cell;
            in_view = (int'(col) < int'(cols)) && (int'(row) < int'(rows));
            if (func == FUNC_WRITE) begin
                if (in_view) frame[int'(row) * MAX_COLS + int'(col)] = {attr, glyph};
                return;
            end
            exp_cell = BLANK_CELL;
            if (in_view) begin
                off = melt_offset(col, row);
                if (off <= 64'(row))
                    exp_cell = frame[(int'(row) - int'(off)) * MAX_COLS + int'(col)];
            end
            expected_cells = {expected_cells, exp_cell};
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            bit [CELL_W-1:0] want;
            if (expected_cells.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with no read outstanding", $time, data);
                return;
            end
            want = expected_cells.pop_front();
            if (data[7:0] !== want[7:0]) begin
                errors++;
                $display("%0t: out_glyph expected %h, actual %h", $time, want[7:0], data[7:0]);
            end
            if (data[15:8] !== want[15:8]) begin
                errors++;
                $display("%0t: out_attribute expected %h, actual %h",
                         $time, want[15:8], data[15:8]);
            end
        endfunction

        function bit drained();
            return expected_cells.size() == 0;
        endfunction
    endclass

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata      = '0;
    logic                  s_tuser      = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    melt_scoreboard sb;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_ack     = 0;
    int unsigned hold_left    = 0;
    logic [COL_W-1:0] last_col = '0;

    cell_column_melt_warp dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Every result transfer is checked against the oldest outstanding read.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Offer one item, with a random gap in front, and record it once the transfer happens.
    task automatic send_item(input logic func, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic [CHAR_W-1:0] glyph,
                             input logic [CHAR_W-1:0] attr);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= IN_DATA_W'({attr, glyph, row, col});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(func, col, row, glyph, attr);
        if (func == FUNC_WRITE) last_col = col;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (!sb.drained()) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Reconfigure only once the block is idle; the unmapped index must change nothing.
    task automatic set_frame(input int cols, input int rows, input int melt);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        write_reg(CFG_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_MELT, CFG_DATA_W'(melt));
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly cells inside the frame; reads often revisit the last written column.
    task automatic send_random_item();
        logic             func;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        func = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_READ;
        if ($urandom_range(0, 99) < 85) begin
            col = COL_W'($urandom_range(0, int'(sb.cols) - 1));
            row = ROW_W'($urandom_range(0, int'(sb.rows) - 1));
            if (func == FUNC_READ && $urandom_range(0, 1) == 1) col = last_col;
        end else begin
            col = COL_W'($urandom);
            row = ROW_W'($urandom);
        end
        send_item(func, col, row, CHAR_W'($urandom), CHAR_W'($urandom));
    endtask

    // Directed cases: frame corners, out-of-frame traffic, zero melt, maximum melt,
    // source above the top and a one-row frame.
    task automatic run_directed();
        send_item(FUNC_WRITE, 0, 0, 8'hFF, 8'hFF);
        send_item(FUNC_READ, 0, 0, 8'h00, 8'h00);
        send_item(FUNC_WRITE, 79, 24, 8'h00, 8'h00);
        send_item(FUNC_READ, 79, 24, 8'hFF, 8'hFF);
        send_item(FUNC_WRITE, 80, 0, 8'h11, 8'h22);
        send_item(FUNC_READ, 80, 0, 8'h00, 8'h00);
        send_item(FUNC_WRITE, 0, 25, 8'h33, 8'h44);
        send_item(FUNC_READ, 0, 25, 8'h00, 8'h00);
        send_item(FUNC_WRITE, 127, 63, 8'h55, 8'h66);
        send_item(FUNC_READ, 127, 63, 8'h00, 8'h00);
        send_item(FUNC_READ, 5, 5, 8'h00, 8'h00);
        send_item(FUNC_WRITE, 79, 0, 8'h5A, 8'hA5);
        send_item(FUNC_READ, 79, 0, 8'h00, 8'h00);
        set_frame(128, 64, 65535);
        send_item(FUNC_READ, 79, 24, 8'h00, 8'h00);
        send_item(FUNC_READ, 0, 0, 8'h00, 8'h00);
        send_item(FUNC_WRITE, 127, 63, 8'hFF, 8'h00);
        send_item(FUNC_READ, 127, 63, 8'h00, 8'h00);
        set_frame(128, 64, 64);
        send_item(FUNC_WRITE, 127, 62, 8'h00, 8'hFF);
        send_item(FUNC_READ, 127, 63, 8'h00, 8'h00);
        set_frame(80, 1, 0);
        send_item(FUNC_READ, 0, 0, 8'h00, 8'h00);
        send_item(FUNC_READ, 0, 1, 8'h00, 8'h00);
    endtask

    task automatic run_phase(input int p);
        case (p)
            0: set_frame(128, 64, 0);
            1: set_frame(1, 1, 65535);
            2: set_frame(12, 64, $urandom_range(0, 4096));
            3: set_frame(128, 2, $urandom_range(0, 4096));
            default: set_frame($urandom_range(1, 24), $urandom_range(1, 64),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 6000));
        endcase
        // Idling pattern rotates: none, sender only, receiver only, both.
        case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
            default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
        endcase
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == 20) hold_req++;
            if (p == 5 && i == 120) wait_drained();
            send_random_item();
        end
        wait_drained();
    endtask

    // Cycle counter that ends a hung run.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) run_phase(p);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cmw_pkg.sv
hw/rtl/cmw_ram.sv
hw/rtl/cmw_offset.sv
hw/rtl/cell_column_melt_warp.sv
verif/tb_cell_column_melt_warp.sv
